// ===== design/srtp_pkg.sv =====
`timescale 1ns / 1ps

package srtp_pkg;

  // Request types carried by req_type.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_KEY  = 2'd1;
  localparam logic [1:0] REQ_SEND = 2'd2;

  // Report causes.
  localparam logic [2:0] CAUSE_RESET = 3'd0;
  localparam logic [2:0] CAUSE_DELTA = 3'd1;
  localparam logic [2:0] CAUSE_TIMER = 3'd2;
  localparam logic [2:0] CAUSE_KEY   = 3'd3;
  localparam logic [2:0] CAUSE_LEAK  = 3'd4;
  localparam logic [2:0] CAUSE_LEVEL = 3'd5;
  localparam logic [2:0] CAUSE_LOW   = 3'd6;

  // Water levels.
  localparam logic [1:0] LVL_UNKNOWN = 2'd0;
  localparam logic [1:0] LVL_LOW     = 2'd1;
  localparam logic [1:0] LVL_MEDIAN  = 2'd2;
  localparam logic [1:0] LVL_HIGH    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HEARTBEAT   = 2'd0;
  localparam logic [1:0] CFG_WATER_HB    = 2'd1;
  localparam logic [1:0] CFG_DELTA_THR   = 2'd2;
  localparam logic [1:0] CFG_REPEAT_LIM  = 2'd3;

  localparam logic [15:0] HEARTBEAT_RST  = 16'd165;
  localparam logic [15:0] WATER_HB_RST   = 16'd55;
  localparam logic [15:0] DELTA_THR_RST  = 16'd100;
  localparam logic [7:0]  REPEAT_LIM_RST = 8'd4;

  // Probe resistance windows, lower bound exclusive, upper bound inclusive.
  localparam logic [15:0] OHMS_HIGH_LO = 16'd6693;
  localparam logic [15:0] OHMS_HIGH_HI = 16'd9234;
  localparam logic [15:0] OHMS_LOW_LO  = 16'd10039;
  localparam logic [15:0] OHMS_LOW_HI  = 16'd13851;
  localparam logic [15:0] OHMS_MED_LO  = 16'd20078;
  localparam logic [15:0] OHMS_MED_HI  = 16'd27702;

  // Repeat counter slots.
  localparam int RC_LOW  = 0;
  localparam int RC_MED  = 1;
  localparam int RC_HIGH = 2;

  localparam logic [7:0] RC_MAX = 8'd255;
  localparam int DIV_BITS = 16;
  localparam logic [3:0] DIV_LAST = 4'(DIV_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_e;

  function automatic logic [1:0] classify(input logic [15:0] ohms);
    logic [1:0] lvl;
    lvl = LVL_UNKNOWN;
    if (ohms > OHMS_HIGH_LO && ohms <= OHMS_HIGH_HI) lvl = LVL_HIGH;
    if (ohms > OHMS_LOW_LO && ohms <= OHMS_LOW_HI) lvl = LVL_LOW;
    if (ohms > OHMS_MED_LO && ohms <= OHMS_MED_HI) lvl = LVL_MEDIAN;
    return lvl;
  endfunction

  function automatic logic [15:0] eff(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic in_repeat(input logic [7:0] c, input logic [7:0] lim);
    return (c != 8'd0) && (c <= lim);
  endfunction

  function automatic logic [7:0] bump(input logic [7:0] c);
    return (c == RC_MAX) ? c : c + 8'd1;
  endfunction

  function automatic logic [15:0] level_centi(input logic [1:0] lvl);
    logic [15:0] v;
    case (lvl)
      LVL_LOW:    v = 16'd100;
      LVL_MEDIAN: v = 16'd200;
      LVL_HIGH:   v = 16'd300;
      default:    v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/sensor_report_trigger_policy.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    req_type, temp_centi, probe_ohms, send_ok
// out       output     out_valid_o / out_ready_i  push_request, cause_code, water_level,
//                                                 report_value
// cfg       input      cfg_we_i (no wait)         cfg_index_i, cfg_value_i
//
// A sample tick passes from its input transfer through a setup state, the
// bit-serial remainder unit that reduces the tick count by the water heartbeat,
// and a commit state, in which its result is loaded into the output register.
// Key press and send outcome items skip the remainder unit.
// Reset is asynchronous and active low; it loads the boot report state.
// The next item is taken while a result still waits in the output register;
// a stalled output holds the block only in its commit cycle.
`timescale 1ns / 1ps

module sensor_report_trigger_policy (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic signed [15:0] temp_centi_i,
  input  logic [15:0] probe_ohms_i,
  input  logic        send_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        push_request_o,
  output logic [2:0]  cause_code_o,
  output logic [1:0]  water_level_o,
  output logic signed [15:0] report_value_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_value_i
);
  import srtp_pkg::*;

  state_e state_q, state_d;

  // Configuration.
  logic [15:0] hb_q, whb_q, thr_q;
  logic [7:0]  lim_q;
  logic [15:0] hb_eff, whb_eff;

  // Policy state.
  logic        pending_q, pending_d;
  logic [2:0]  cause_q, cause_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] last_temp_q, last_temp_d;
  logic [15:0] cur_temp_q, cur_temp_d;
  logic [1:0]  last_lvl_q, last_lvl_d;
  logic [1:0]  cur_lvl_q, cur_lvl_d;
  logic [7:0]  rc_q [3];
  logic [7:0]  rc_d [3];

  // Latched input item and remainder unit.
  logic [1:0]  req_q;
  logic [15:0] temp_q, ohms_q;
  logic        ok_q;
  logic        timer_hit_q, timer_hit_d;
  logic [15:0] rem_q, rem_d, dvd_q, dvd_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [16:0] trial;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        push_q;
  logic [2:0]  cause_out_q;
  logic [1:0]  lvl_out_q;
  logic [15:0] rv_q, rv_d;

  logic        fin_go;
  logic        accept;
  logic [15:0] tick_inc;
  logic [16:0] dt, mag;
  logic [1:0]  lvl_new;
  logic        due;

  assign hb_eff   = eff(hb_q);
  assign whb_eff  = eff(whb_q);
  assign accept   = in_valid_i && in_ready_o;
  assign tick_inc = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  assign dt       = {temp_q[15], temp_q} - {last_temp_q[15], last_temp_q};
  assign mag      = dt[16] ? (17'd0 - dt) : dt;
  assign trial    = {rem_q, dvd_q[15]};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_PREP;
      ST_PREP: state_d = (req_q == REQ_TICK) ? ST_DIV : ST_FIN;
      ST_DIV:  if (cnt_q == DIV_LAST) state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    fin_go     = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_FIN:  fin_go = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Remainder unit: one restoring step per cycle.
  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    cnt_d = cnt_q;
    timer_hit_d = timer_hit_q;
    if (state_q == ST_PREP) begin
      timer_hit_d = (tick_inc >= hb_eff);
      dvd_d = (tick_inc >= hb_eff) ? 16'd0 : tick_inc;
      rem_d = 16'd0;
      cnt_d = 4'd0;
    end else if (state_q == ST_DIV) begin
      rem_d = (trial >= {1'b0, whb_eff}) ? 16'(trial - {1'b0, whb_eff}) : trial[15:0];
      dvd_d = {dvd_q[14:0], 1'b0};
      cnt_d = cnt_q + 4'd1;
    end
  end

  // Policy update, committed in an item's last cycle; a tick advances the tick count in setup.
  always_comb begin
    pending_d   = pending_q;
    cause_d     = cause_q;
    tick_d      = tick_q;
    last_temp_d = last_temp_q;
    cur_temp_d  = cur_temp_q;
    last_lvl_d  = last_lvl_q;
    cur_lvl_d   = cur_lvl_q;
    rc_d        = rc_q;
    lvl_new     = classify(ohms_q);

    if (state_q == ST_PREP && req_q == REQ_TICK) begin
      tick_d = (tick_inc >= hb_eff) ? 16'd0 : tick_inc;
    end

    if (fin_go) begin
      case (req_q)
        REQ_TICK: begin
          cur_temp_d = temp_q;
          cur_lvl_d  = lvl_new;
          if (mag > {1'b0, thr_q}) begin
            pending_d = 1'b1;
            cause_d   = CAUSE_DELTA;
          end
          if (timer_hit_q) begin
            pending_d = 1'b1;
            cause_d   = CAUSE_TIMER;
          end
          if ((lvl_new == LVL_HIGH || lvl_new == LVL_MEDIAN) && rem_q == 16'd0) begin
            pending_d = 1'b1;
            cause_d   = CAUSE_TIMER;
          end
          if (lvl_new != last_lvl_q) begin
            pending_d = 1'b1;
            cause_d   = CAUSE_LEVEL;
            if (lvl_new == LVL_MEDIAN) rc_d[RC_MED] = bump(rc_q[RC_MED]);
            if (lvl_new == LVL_HIGH) rc_d[RC_HIGH] = bump(rc_q[RC_HIGH]);
            if (lvl_new == LVL_LOW) rc_d[RC_LOW] = bump(rc_q[RC_LOW]);
          end else begin
            if (lvl_new == LVL_HIGH && in_repeat(rc_q[RC_HIGH], lim_q)) begin
              pending_d = 1'b1;
              cause_d   = CAUSE_LEAK;
              rc_d[RC_HIGH] = bump(rc_q[RC_HIGH]);
            end
            if (lvl_new == LVL_LOW && in_repeat(rc_q[RC_LOW], lim_q)) begin
              pending_d = 1'b1;
              cause_d   = CAUSE_LOW;
              rc_d[RC_LOW] = bump(rc_q[RC_LOW]);
            end
            if (lvl_new == LVL_MEDIAN && in_repeat(rc_q[RC_MED], lim_q)) begin
              pending_d = 1'b1;
              cause_d   = CAUSE_LEAK;
              rc_d[RC_MED] = bump(rc_q[RC_MED]);
            end
            if (lvl_new != LVL_HIGH) rc_d[RC_HIGH] = 8'd0;
            if (lvl_new != LVL_LOW) rc_d[RC_LOW] = 8'd0;
            if (lvl_new != LVL_MEDIAN) rc_d[RC_MED] = 8'd0;
          end
        end
        REQ_KEY: begin
          pending_d = 1'b1;
          cause_d   = CAUSE_KEY;
        end
        REQ_SEND: begin
          if (pending_q) begin
            // A key or boot report takes the sample that comes with the outcome.
            if (cause_q == CAUSE_KEY || cause_q == CAUSE_RESET) begin
              cur_lvl_d  = lvl_new;
              cur_temp_d = temp_q;
            end
            if (cur_lvl_d != last_lvl_q || cause_q == CAUSE_TIMER ||
                cause_q == CAUSE_LEAK || in_repeat(rc_q[RC_LOW], lim_q)) begin
              cur_temp_d = level_centi(cur_lvl_d);
            end
            if (ok_q) begin
              last_temp_d = cur_temp_d;
              last_lvl_d  = cur_lvl_d;
            end else if (cause_q == CAUSE_TIMER) begin
              tick_d = (cur_lvl_d == LVL_LOW) ? hb_eff - 16'd1 : whb_eff - 16'd1;
            end
            pending_d = 1'b0;
          end
        end
        default: ;
      endcase
    end

    due  = (cur_lvl_d != last_lvl_d) || cause_d == CAUSE_TIMER ||
           cause_d == CAUSE_LEAK || in_repeat(rc_d[RC_LOW], lim_q);
    rv_d = due ? level_centi(cur_lvl_d) : cur_temp_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hb_q        <= HEARTBEAT_RST;
      whb_q       <= WATER_HB_RST;
      thr_q       <= DELTA_THR_RST;
      lim_q       <= REPEAT_LIM_RST;
      pending_q   <= 1'b1;
      cause_q     <= CAUSE_RESET;
      tick_q      <= 16'd0;
      last_temp_q <= 16'd0;
      cur_temp_q  <= 16'd0;
      last_lvl_q  <= LVL_UNKNOWN;
      cur_lvl_q   <= LVL_UNKNOWN;
      rc_q[RC_LOW]  <= 8'd0;
      rc_q[RC_MED]  <= 8'd0;
      rc_q[RC_HIGH] <= 8'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HEARTBEAT:  hb_q  <= cfg_value_i;
          CFG_WATER_HB:   whb_q <= cfg_value_i;
          CFG_DELTA_THR:  thr_q <= cfg_value_i;
          CFG_REPEAT_LIM: lim_q <= cfg_value_i[7:0];
          default: ;
        endcase
      end
      pending_q   <= pending_d;
      cause_q     <= cause_d;
      tick_q      <= tick_d;
      last_temp_q <= last_temp_d;
      cur_temp_q  <= cur_temp_d;
      last_lvl_q  <= last_lvl_d;
      cur_lvl_q   <= cur_lvl_d;
      rc_q        <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      temp_q <= temp_centi_i;
      ohms_q <= probe_ohms_i;
      ok_q   <= send_ok_i;
    end
    timer_hit_q <= timer_hit_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    cnt_q       <= cnt_d;
    if (fin_go) begin
      push_q      <= pending_d;
      cause_out_q <= cause_d;
      lvl_out_q   <= cur_lvl_d;
      rv_q        <= rv_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign push_request_o = push_q;
  assign cause_code_o   = cause_out_q;
  assign water_level_o  = lvl_out_q;
  assign report_value_o = rv_q;

`ifndef SYNTHESIS
  // During division the partial remainder stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < whb_eff)
    else $error("remainder unit left its range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_PREP)
    else $error("accepted item did not start processing");

  // A send outcome always closes the pending report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go && req_q == REQ_SEND |=> !pending_q)
    else $error("report still pending after send outcome");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go && req_q == REQ_KEY |=> pending_q && cause_q == CAUSE_KEY && out_valid_o)
    else $error("key press did not raise a key report");
`endif

endmodule
